>>> design/cbc_pkg.sv
// Shared constants and codes for the cartridge bank controller.
package cbc_pkg;

    // Storage sizes.
    localparam int RAM_BYTES     = 32768;
    localparam int RAM_AW        = $clog2(RAM_BYTES);
    localparam int MAX_ROM_BANKS = 128;

    // Configuration register indexes.
    localparam logic [1:0] CFG_MBC_ENABLED    = 2'd0;
    localparam logic [1:0] CFG_ROM_BANK_COUNT = 2'd1;
    localparam logic [1:0] CFG_RAM_SIZE_CODE  = 2'd2;

    // Access kinds.
    localparam logic REQ_READ  = 1'b0;
    localparam logic REQ_WRITE = 1'b1;

    // Cartridge RAM size codes.
    localparam logic [1:0] RAM_SIZE_NONE = 2'd0;
    localparam logic [1:0] RAM_SIZE_8K   = 2'd1;
    localparam logic [1:0] RAM_SIZE_32K  = 2'd2;

    // Control register windows, selected by address bits 14:13.
    localparam logic [1:0] WIN_RAM_ENABLE = 2'd0;
    localparam logic [1:0] WIN_BANK_LOW   = 2'd1;
    localparam logic [1:0] WIN_BANK_HIGH  = 2'd2;
    localparam logic [1:0] WIN_BANK_MODE  = 2'd3;

    // Top three address bits of the cartridge RAM window A000-BFFF.
    localparam logic [2:0] RAM_WINDOW = 3'b101;

    // Byte returned when nothing drives the bus.
    localparam logic [7:0] OPEN_BUS = 8'hFF;

    // RAM-enable key in the low nibble.
    localparam logic [3:0] RAM_KEY = 4'hA;

endpackage

>>> design/cartridge_bank_controller.sv
// Cartridge bank controller: register decode, ROM address mapping and banked RAM.
//
// Usage:
//   Input channel s_*: one CPU bus access per item. s_tuser carries the access
//   kind (0 read, 1 write); s_tdata carries the address and the write byte.
//   Result channel m_*: exactly one result item per access, in order.
//   m_tuser flags a ROM read, in which case the external ROM must return the
//   byte at the ROM address in m_tdata; otherwise m_tdata holds the RAM byte or
//   0xFF.
//   Configuration channel cfg_*: always ready; writes are to be made while the block
//   is idle, which the block does not enforce. Index 0 is mbc_enabled, 1 is rom_bank_count, 2 is ram_size_code.
//   An accepted item passes the input register and then the result register;
//   one item is accepted every cycle while the receiver does not stall, set by
//   the decode stage and the one-port cartridge RAM, written and read once per cycle.
//   Reset clears the pipeline and returns the configuration and bank registers
//   to their defaults; RAM contents are undefined until written.
//   When the receiver stalls, the result register holds its item and the input
//   register still takes one more item before s_tready falls.
module cartridge_bank_controller (
    input  logic        aclk,
    input  logic        aresetn,
    // Input items.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [15:0] address, [23:16] write_data
    input  logic [0:0]  s_tuser,   // [0] req_type
    // Result items.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [20:0] rom_address, [28:21] read_data, rest zero
    output logic [0:0]  m_tuser,   // [0] rom_read
    // Configuration writes.
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data
);

    // Configuration registers.
    logic       mbc_enabled_reg;
    logic [7:0] rom_bank_count_reg;
    logic [1:0] ram_size_code_reg;

    // Bank state.
    logic       ram_enable_reg, ram_enable_next;
    logic [4:0] bank_low_reg, bank_low_next;
    logic [1:0] bank_high_reg, bank_high_next;
    logic       bank_mode_reg, bank_mode_next;

    // Input stage.
    logic        in_valid_reg;
    logic        in_type_reg;
    logic [15:0] in_addr_reg;
    logic [7:0]  in_data_reg;

    // Result stage.
    logic        out_valid_reg;
    logic        rom_read_reg, rom_read_next;
    logic [20:0] rom_addr_reg, rom_addr_next;
    logic        ram_hit_reg, ram_hit_next;
    logic [7:0]  ram_q_reg;

    // Decode signals.
    logic                        advance;
    logic                        fire;
    logic [6:0]                  rom_bank;
    logic [7:0]                  rom_limit;
    logic [1:0]                  ram_bank;
    logic [15:0]                 ram_off;
    logic [16:0]                 ram_size;
    logic                        ram_access;
    logic                        ram_write;
    logic [cbc_pkg::RAM_AW-1:0]  ram_index;

    // Cartridge RAM.
    logic [7:0] ram_mem [cbc_pkg::RAM_BYTES];

    // Handshake: the input stage moves on whenever the result register is free.
    assign advance   = !out_valid_reg || m_tready;
    assign fire      = advance && in_valid_reg;
    assign s_tready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    // ROM bank mapping and limit check.
    always_comb begin
        rom_bank = (bank_mode_reg == 1'b0) ? {bank_high_reg, bank_low_reg}
                                           : {2'b00, bank_low_reg};
        if (rom_bank_count_reg > 8'(cbc_pkg::MAX_ROM_BANKS)) begin
            rom_limit = 8'(cbc_pkg::MAX_ROM_BANKS);
        end else begin
            rom_limit = rom_bank_count_reg;
        end
    end

    // Cartridge RAM size and offset.
    always_comb begin
        case (ram_size_code_reg)
            cbc_pkg::RAM_SIZE_8K:  ram_size = 17'd8192;
            cbc_pkg::RAM_SIZE_32K: ram_size = 17'd32768;
            default:               ram_size = 17'd0;
        endcase
        if (ram_size > 17'(cbc_pkg::RAM_BYTES)) begin
            ram_size = 17'(cbc_pkg::RAM_BYTES);
        end
        ram_bank   = bank_mode_reg ? bank_high_reg : 2'b00;
        ram_off    = {1'b0, ram_bank, in_addr_reg[12:0]};
        ram_access = (in_addr_reg[15:13] == cbc_pkg::RAM_WINDOW) && ram_enable_reg
                     && (ram_size != 17'd0) && ({1'b0, ram_off} < ram_size);
        ram_write  = fire && ram_access && (in_type_reg == cbc_pkg::REQ_WRITE);
        ram_index  = ram_off[cbc_pkg::RAM_AW-1:0];
    end

    // Result of the access in the input stage.
    always_comb begin
        rom_read_next = 1'b0;
        rom_addr_next = 21'd0;
        ram_hit_next  = ram_access && (in_type_reg == cbc_pkg::REQ_READ);
        if (!in_addr_reg[15] && in_type_reg == cbc_pkg::REQ_READ) begin
            if (!in_addr_reg[14]) begin
                rom_read_next = 1'b1;
                rom_addr_next = {7'd0, in_addr_reg[13:0]};
            end else if ({1'b0, rom_bank} < rom_limit) begin
                rom_read_next = 1'b1;
                rom_addr_next = {rom_bank, in_addr_reg[13:0]};
            end
        end
    end

    // Control register writes from the bus.
    always_comb begin
        ram_enable_next = ram_enable_reg;
        bank_low_next   = bank_low_reg;
        bank_high_next  = bank_high_reg;
        bank_mode_next  = bank_mode_reg;
        if (fire && mbc_enabled_reg && !in_addr_reg[15]
            && in_type_reg == cbc_pkg::REQ_WRITE) begin
            case (in_addr_reg[14:13])
                cbc_pkg::WIN_RAM_ENABLE: ram_enable_next = (in_data_reg[3:0] == cbc_pkg::RAM_KEY);
                cbc_pkg::WIN_BANK_LOW: begin
                    bank_low_next = (in_data_reg[4:0] == 5'd0) ? 5'd1 : in_data_reg[4:0];
                end
                cbc_pkg::WIN_BANK_HIGH:  bank_high_next = in_data_reg[1:0];
                cbc_pkg::WIN_BANK_MODE:  bank_mode_next = in_data_reg[0];
                default:                 bank_mode_next = bank_mode_reg;
            endcase
        end
    end

    // Configuration, bank state and pipeline control.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mbc_enabled_reg    <= 1'b0;
            rom_bank_count_reg <= 8'd2;
            ram_size_code_reg  <= cbc_pkg::RAM_SIZE_NONE;
            ram_enable_reg     <= 1'b0;
            bank_low_reg       <= 5'd1;
            bank_high_reg      <= 2'd0;
            bank_mode_reg      <= 1'b0;
            in_valid_reg       <= 1'b0;
            out_valid_reg      <= 1'b0;
        end else begin
            if (cfg_valid) begin
                case (cfg_index)
                    cbc_pkg::CFG_MBC_ENABLED:    mbc_enabled_reg    <= cfg_data[0];
                    cbc_pkg::CFG_ROM_BANK_COUNT: rom_bank_count_reg <= cfg_data;
                    cbc_pkg::CFG_RAM_SIZE_CODE:  ram_size_code_reg  <= cfg_data[1:0];
                    default:                     mbc_enabled_reg    <= mbc_enabled_reg;
                endcase
            end
            ram_enable_reg <= ram_enable_next;
            bank_low_reg   <= bank_low_next;
            bank_high_reg  <= bank_high_next;
            bank_mode_reg  <= bank_mode_next;
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (advance) begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    // Payload registers of both stages.
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_type_reg <= s_tuser[0];
            in_addr_reg <= s_tdata[15:0];
            in_data_reg <= s_tdata[23:16];
        end
        if (fire) begin
            rom_read_reg <= rom_read_next;
            rom_addr_reg <= rom_addr_next;
            ram_hit_reg  <= ram_hit_next;
        end
    end

    // Cartridge RAM port: a write for a RAM write item and a registered read for every item.
    always_ff @(posedge aclk) begin
        if (ram_write) begin
            ram_mem[ram_index] <= in_data_reg;
        end
        if (fire) begin
            ram_q_reg <= ram_mem[ram_index];
        end
    end

    // Result outputs.
    assign m_tvalid   = out_valid_reg;
    assign m_tuser[0] = rom_read_reg;
    assign m_tdata    = {3'b000, (ram_hit_reg ? ram_q_reg : cbc_pkg::OPEN_BUS), rom_addr_reg};

    // A ROM read never also returns a RAM byte.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata[28:21] == cbc_pkg::OPEN_BUS)
        else $error("ROM read result carries RAM data");

    // The ROM address is zero unless the ROM is read.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tdata[20:0] == 21'd0)
        else $error("nonzero ROM address without ROM read");

    // An empty result register never blocks the input.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !out_valid_reg |-> s_tready)
        else $error("input stalled with empty result register");

    // The low ROM bank register never holds zero.
    assert property (@(posedge aclk) disable iff (!aresetn)
        bank_low_reg != 5'd0)
        else $error("low ROM bank is zero");

endmodule
